[rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants for the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W           = 32;
    localparam int CFG_W              = 7;
    localparam int WINDOW_MAX_DEFAULT = 64;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_INSERT,
        ST_OUT
    } swm_state_t;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic remove;
        logic replace;
        logic load_out;
    } swm_cmd_t;

    typedef struct packed {
        logic full;
        logic last_fill;
        logic out_busy;
    } swm_stat_t;

endpackage

[rtl/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/swm_datapath.sv]
// ----------------------------------------------------------------------------
// swm_datapath
// sorted cell row, history ram, window counters and output register
// ----------------------------------------------------------------------------
module swm_datapath
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  swm_cmd_t            cmd,
    output swm_stat_t           stat,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [SAMPLE_W-1:0] m_tdata
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]           window_size_reg;
    logic [KW-1:0]              fill_reg;
    logic [AW-1:0]              oldest_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] median_reg;
    logic                       out_valid_reg;

    logic signed [SAMPLE_W-1:0] cell_reg  [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] cell_next [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      gt;
    logic [WINDOW_MAX-1:0]      lt;

    logic [KW-1:0]         k;
    logic [KW-1:0]         ins_n;
    logic [KW-1:0]         k_dec;
    logic [AW-1:0]         med_idx;
    logic [AW-1:0]         slot;
    logic [KW-1:0]         slot_inc;
    logic [AW-1:0]         oldest_next;
    logic                  hist_wr;
    logic [AW-1:0]         hist_wr_addr;
    logic [SAMPLE_W-1:0]   hist_rd;
    logic                  win_clear;

    // effective window length, clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = KW'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            k = KW'(WINDOW_MAX);
        end
        else
        begin
            k = KW'(window_size_reg);
        end
    end

    assign k_dec   = k - KW'(1);
    assign med_idx = AW'(k_dec >> 1);
    assign ins_n   = cmd.replace ? k_dec : fill_reg;

    assign slot        = (KW'(oldest_reg) >= k) ? '0 : oldest_reg;
    assign slot_inc    = KW'(slot) + KW'(1);
    assign oldest_next = (slot_inc >= k) ? '0 : slot_inc[AW-1:0];

    assign hist_wr      = cmd.fill_step | cmd.replace;
    assign hist_wr_addr = cmd.fill_step ? fill_reg[AW-1:0] : slot;

    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_history (
        .clk     (clk),
        .wr_en   (hist_wr),
        .wr_addr (hist_wr_addr),
        .wr_data (sample_reg),
        .rd_addr (slot),
        .rd_data (hist_rd)
    );

    // compare-and-shift cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] below;
        logic signed [SAMPLE_W-1:0] above;
        logic                       gt_below;

        if (i == 0)
        begin : g_first
            assign below    = cell_reg[0];
            assign gt_below = 1'b0;
        end
        else
        begin : g_rest
            assign below    = cell_reg[i-1];
            assign gt_below = gt[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign above = cell_reg[i];
        end
        else
        begin : g_inner
            assign above = cell_reg[i+1];
        end

        assign gt[i] = (KW'(i) < ins_n) && (cell_reg[i] > sample_reg);
        assign lt[i] = cell_reg[i] < $signed(hist_rd);

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.fill_step || cmd.replace)
            begin
                if (gt_below)
                begin
                    cell_next[i] = below;
                end
                else if (gt[i] || (KW'(i) == ins_n))
                begin
                    cell_next[i] = sample_reg;
                end
            end
            else if (cmd.remove)
            begin
                if (!lt[i])
                begin
                    cell_next[i] = above;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign win_clear = cfg_wen | (cmd.accept & s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                window_size_reg <= cfg_wdata;
            end

            if (win_clear)
            begin
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            else
            begin
                if (cmd.fill_step)
                begin
                    fill_reg <= fill_reg + KW'(1);
                end
                if (cmd.replace)
                begin
                    oldest_reg <= oldest_next;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= $signed(s_tdata);
        end
        if (cmd.load_out)
        begin
            median_reg <= cell_reg[med_idx];
        end
    end

    assign stat.full      = (fill_reg >= k);
    assign stat.last_fill = ((fill_reg + KW'(1)) == k);
    assign stat.out_busy  = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = median_reg;

endmodule

[rtl/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer for fill, remove, insert and result load steps
// ----------------------------------------------------------------------------
module swm_ctrl
    import swm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output swm_cmd_t  cmd,
    input  swm_stat_t stat
);

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!stat.full)
                begin
                    cmd.fill_step = 1'b1;
                    state_next    = stat.last_fill ? ST_OUT : ST_IDLE;
                end
                else
                begin
                    // drop oldest word from the sorted row
                    cmd.remove = 1'b1;
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.replace = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sliding_window_median_core.sv]
// sequence: m_tvalid rises after the states EVAL and OUT for the sample that completes k,
//   after EVAL, INSERT and OUT once the window is full; OUT waits while the output is stalled
// a new sample is taken only in IDLE, after the previous one is done: a fill step while filling,
//   a remove pass and an insert pass of the sorted cell row after the history read once full
// reset: asynchronous, window_size returns to 3 and the window is emptied, no clearing pass
// ----------------------------------------------------------------------------
// sliding_window_median_core
// running median over the last k signed samples, k set by window_size
// ----------------------------------------------------------------------------
module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,  // window_size
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // sample
    input  logic                s_tuser,    // restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata     // median
);

    swm_cmd_t  cmd;
    swm_stat_t stat;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

[tb/sliding_window_median_checker.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_checker
// Watches the configuration port and both stream channels of the median
// filter. It keeps its own sorted copy of the window and predicts the median
// for every accepted sample that completes a full window. Each median word
// that arrives is compared with the oldest prediction, and every mismatch is counted.
// ----------------------------------------------------------------------------
module sliding_window_median_checker
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SAMPLE_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  pending
);

    localparam int WIN_MAX = WINDOW_MAX_DEFAULT;

    logic signed [SAMPLE_W-1:0] arrival_hist [WIN_MAX];
    logic signed [SAMPLE_W-1:0] sorted_win [WIN_MAX];
    logic [CFG_W-1:0]           win_size;
    int                         fill_count;
    int                         oldest_slot;

    logic signed [SAMPLE_W-1:0] expected_medians [$];
    logic signed [SAMPLE_W-1:0] want_median;
    logic signed [SAMPLE_W-1:0] new_median;
    bit                         has_median;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic insert_sorted(input int n, input logic signed [SAMPLE_W-1:0] v);
        int i;
        i = n;
        while (i > 0 && sorted_win[i-1] > v)
        begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = v;
    endtask

    // an absent value leaves the top entry as the one dropped
    task automatic remove_sorted(input int n, input logic signed [SAMPLE_W-1:0] v);
        int i;
        i = 0;
        while (i < n && sorted_win[i] != v)
            i++;
        while (i + 1 < n)
        begin
            sorted_win[i] = sorted_win[i+1];
            i++;
        end
    endtask

    task automatic slide_window(
        input  logic signed [SAMPLE_W-1:0] smp,
        input  logic                       new_seq,
        output bit                         produced,
        output logic signed [SAMPLE_W-1:0] median
    );
        int k;
        int slot;
        k = win_size;
        if (k < 1)
            k = 1;
        if (k > WIN_MAX)
            k = WIN_MAX;
        if (new_seq)
        begin
            fill_count  = 0;
            oldest_slot = 0;
        end
        if (fill_count < k)
        begin
            arrival_hist[fill_count] = smp;
            insert_sorted(fill_count, smp);
            fill_count++;
            produced = (fill_count == k);
        end
        else
        begin
            slot = oldest_slot;
            if (slot >= k)
                slot = 0;
            remove_sorted(k, arrival_hist[slot]);
            insert_sorted(k - 1, smp);
            arrival_hist[slot] = smp;
            slot++;
            oldest_slot = (slot >= k) ? 0 : slot;
            produced = 1'b1;
        end
        median = sorted_win[(k - 1) / 2];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size    = WINDOW_SIZE_RESET;
            fill_count  = 0;
            oldest_slot = 0;
            expected_medians.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_medians.size() == 0)
                    report_mismatch($sformatf("median word %0d with none expected",
                                              $signed(m_tdata)));
                else
                begin
                    want_median = expected_medians.pop_front();
                    if (m_tdata !== want_median)
                        report_mismatch($sformatf("median mismatch: got %0d, expected %0d",
                                                  $signed(m_tdata), want_median));
                end
            end
            if (cfg_wen)
            begin
                win_size    = cfg_wdata;
                fill_count  = 0;
                oldest_slot = 0;
            end
            if (s_tvalid && s_tready)
            begin
                slide_window(s_tdata, s_tuser, has_median, new_median);
                if (has_median)
                    expected_medians.insert(expected_medians.size(), new_median);
            end
        end
        pending = expected_medians.size();
    end

endmodule

[tb/sliding_window_median_core_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_core_test
// Drives the median filter with a directed run of extreme, duplicate and
// restart samples, then with random sequences over a series of window sizes
// including zero, one, the maximum and saturating values. Both stream sides
// stall at random; a separate checker predicts and compares every median.
// ----------------------------------------------------------------------------
module sliding_window_median_core_test
    import swm_pkg::*;
();

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO  = 32'h0000_0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_M1    = 32'hffff_ffff;
    localparam int                  SETTLE       = 12;
    localparam int                  PHASES       = 12;
    localparam int                  PHASE_ITEMS  = 170;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;

    int mismatches;
    int pending;
    bit tx_busy;
    bit rx_busy;
    int rx_count;
    int k_eff;

    logic [CFG_W-1:0] size_plan [8] = '{7'd5, 7'd1, 7'd0, 7'd64, 7'd2, 7'd127, 7'd4, 7'd65};

    sliding_window_median_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sliding_window_median_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("sliding_window_median_core_test: FAIL");
        $finish;
    end

    // mix of extremes, a narrow band for duplicates, and full-range words
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return SAMPLE_ZERO;
                default: return SAMPLE_M1;
            endcase
        end
        else if (r <= 3)
            return $urandom_range(0, 15) - 8;
        else
            return $urandom;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic new_seq);
        int gap;
        gap = tx_busy ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= value;
        s_tuser  <= new_seq;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_medians(input int settle);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_window_size(input logic [CFG_W-1:0] value);
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        k_eff = (value < 1) ? 1 : (value > WINDOW_MAX_DEFAULT) ? WINDOW_MAX_DEFAULT : value;
    endtask

    // median receiver
    initial
    begin
        int gap;
        m_tready = 1'b0;
        rx_busy  = 1'b1;
        rx_count = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_count % 40 == 0)
                rx_busy = ($urandom_range(0, 2) != 0);
            gap = rx_busy ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            rx_count++;
        end
    end

    initial
    begin
        int n;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        rst_n     = 1'b0;
        tx_busy   = 1'b1;
        k_eff     = WINDOW_SIZE_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default window of three: extremes, duplicates, restarts
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_ZERO, 1'b0);
        send_sample(SAMPLE_M1, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(32'd5, 1'b1);
        send_sample(32'd5, 1'b0);
        send_sample(-32'sd7, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(32'd9, 1'b1);
        send_sample(32'd3, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_medians(SETTLE);
            write_window_size((p < 8) ? size_plan[p] : CFG_W'($urandom_range(1, 20)));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 60)
                    drain_medians(0);
                if (n % 40 == 0)
                    tx_busy = ($urandom_range(0, 2) != 0);
                send_sample(pick_sample(), $urandom_range(0, 3 * k_eff) == 0);
            end
        end

        drain_medians(SETTLE);
        if (mismatches == 0)
            $display("sliding_window_median_core_test: PASS");
        else
            $display("sliding_window_median_core_test: FAIL");
        $finish;
    end

endmodule
